// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent check helpers clocked on aclk, disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, ante, cons)
`define ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== design/podo_pkg.sv =====
// ---------------------------------------------------------------------------
// podo_pkg
// Shared constants, angle table and controller command type for the pose
// integrator.
// ---------------------------------------------------------------------------
package podo_pkg;

    localparam int ROTATION_ITERATIONS = 16;
    localparam int POSE_WIDTH          = 32;

    localparam int ATAN_ENTRIES = 24;
    localparam int ROT_STEPS    = (ROTATION_ITERATIONS > ATAN_ENTRIES) ?
                                  ATAN_ENTRIES : ROTATION_ITERATIONS;
    localparam int ITER_W       = (ROT_STEPS > 1) ? $clog2(ROT_STEPS) : 1;
    localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);

    localparam int FIELD_W   = 16;
    localparam int HEAD_W    = 16;
    localparam int WORLD_W   = 32;
    localparam int S_TDATA_W = 3 * FIELD_W;
    localparam int M_TDATA_W = 2 * WORLD_W + HEAD_W;

    // CORDIC datapath
    localparam int GUARD_BITS = 16;
    localparam int CORDIC_W   = 36;   // 17-bit vector, 16 guard bits, gain headroom
    localparam int ANGLE_W    = 32;   // 2^-32 turn units

    // gain correction: 1/K in Q30, split multiply over two partial products
    localparam int GAIN_W      = 31;
    localparam int SPLIT       = 18;
    localparam int MUL_A_W     = CORDIC_W - SPLIT + 1;
    localparam int PROD_W      = MUL_A_W + GAIN_W;
    localparam int ACC_W       = 68;
    localparam int ROUND_SHIFT = 46;
    localparam int RX_W        = ACC_W - ROUND_SHIFT;
    localparam int SUM_W       = ((POSE_WIDTH > RX_W) ? POSE_WIDTH : RX_W) + 1;

    localparam logic signed [GAIN_W-1:0] INV_GAIN = 31'sd652032874;

    localparam logic [ANGLE_W-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef enum logic [1:0] {
        MUL_XL,
        MUL_XH,
        MUL_YL,
        MUL_YH
    } mul_phase_t;

    typedef struct packed {
        logic              load;
        logic              rotate;
        logic [ITER_W-1:0] iter;
        logic              scale;
        mul_phase_t        phase;
        logic              update;
    } podo_cmd_t;

endpackage

// ===== design/podo_dpath.sv =====
// ---------------------------------------------------------------------------
// podo_dpath
// Quadrant pre-rotation, iterative CORDIC rotator, split gain multiply and
// saturating position and wrapping heading accumulate, stepped by controller commands.
// ---------------------------------------------------------------------------
module podo_dpath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  podo_pkg::podo_cmd_t            cmd,
    input  logic [podo_pkg::S_TDATA_W-1:0] s_tdata,
    output logic [podo_pkg::M_TDATA_W-1:0] m_tdata
);
    import podo_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_MAX =
        SUM_W'({1'b0, {(POSE_WIDTH-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (ROUND_SHIFT - 1);

    function automatic logic signed [POSE_WIDTH-1:0] sat_pose(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W-1:0] c;
        begin
            if (v > SAT_MAX) begin
                c = SAT_MAX;
            end else if (v < SAT_MIN) begin
                c = SAT_MIN;
            end else begin
                c = v;
            end
            sat_pose = c[POSE_WIDTH-1:0];
        end
    endfunction

    // state and working registers
    logic signed [POSE_WIDTH-1:0] pose_x_reg, pose_x_next;
    logic signed [POSE_WIDTH-1:0] pose_y_reg, pose_y_next;
    logic        [HEAD_W-1:0]     pose_h_reg, pose_h_next;
    logic        [HEAD_W-1:0]     dh_reg;
    logic signed [CORDIC_W-1:0]   x_reg, x_next;
    logic signed [CORDIC_W-1:0]   y_reg, y_next;
    logic signed [ANGLE_W-1:0]    z_reg, z_next;
    logic signed [ACC_W-1:0]      acc_reg, acc_next;
    logic signed [RX_W-1:0]       rx_reg, ry_reg;
    logic        [M_TDATA_W-1:0]  m_data_reg;

    // input decode
    logic signed [FIELD_W-1:0] in_dx, in_dy;
    logic signed [FIELD_W:0]   dx17, dy17, sx, sy;
    logic        [HEAD_W-1:0]  h_bias, r_angle;
    logic        [1:0]         quad;

    assign in_dx = s_tdata[FIELD_W-1:0];
    assign in_dy = s_tdata[2*FIELD_W-1:FIELD_W];
    assign dx17  = {in_dx[FIELD_W-1], in_dx};
    assign dy17  = {in_dy[FIELD_W-1], in_dy};

    // nearest quarter turn, residual in [-1/8, 1/8) turn
    assign h_bias  = pose_h_reg + HEAD_W'(16'h2000);
    assign quad    = h_bias[HEAD_W-1:HEAD_W-2];
    assign r_angle = pose_h_reg - {quad, {(HEAD_W-2){1'b0}}};

    always_comb begin
        unique case (quad)
            2'd1: begin
                sx = -dy17;
                sy = dx17;
            end
            2'd2: begin
                sx = -dx17;
                sy = -dy17;
            end
            2'd3: begin
                sx = dy17;
                sy = -dx17;
            end
            default: begin
                sx = dx17;
                sy = dy17;
            end
        endcase
    end

    // rotation step
    logic signed [CORDIC_W-1:0] xs, ys;
    logic signed [ANGLE_W-1:0]  atan_i;

    assign xs     = x_reg >>> cmd.iter;
    assign ys     = y_reg >>> cmd.iter;
    assign atan_i = ATAN_TURNS[ATAN_IDX_W'(cmd.iter)];

    // gain multiply, one partial product per cycle
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   prod_ext;

    always_comb begin
        unique case (cmd.phase)
            MUL_XL:  mul_a = {1'b0, x_reg[SPLIT-1:0]};
            MUL_XH:  mul_a = {x_reg[CORDIC_W-1], x_reg[CORDIC_W-1:SPLIT]};
            MUL_YL:  mul_a = {1'b0, y_reg[SPLIT-1:0]};
            default: mul_a = {y_reg[CORDIC_W-1], y_reg[CORDIC_W-1:SPLIT]};
        endcase
    end

    assign prod     = mul_a * INV_GAIN;
    assign prod_ext = ACC_W'(prod);

    always_comb begin
        if (cmd.phase == MUL_XL || cmd.phase == MUL_YL) begin
            acc_next = prod_ext + ROUND_BIAS;
        end else begin
            acc_next = acc_reg + (prod_ext <<< SPLIT);
        end
    end

    always_comb begin
        if (cmd.load) begin
            x_next = {{(CORDIC_W-FIELD_W-1-GUARD_BITS){sx[FIELD_W]}}, sx,
                      {GUARD_BITS{1'b0}}};
            y_next = {{(CORDIC_W-FIELD_W-1-GUARD_BITS){sy[FIELD_W]}}, sy,
                      {GUARD_BITS{1'b0}}};
            z_next = {r_angle, {(ANGLE_W-HEAD_W){1'b0}}};
        end else if (!z_reg[ANGLE_W-1]) begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - atan_i;
        end else begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + atan_i;
        end
    end

    // pose update
    assign pose_x_next = sat_pose(SUM_W'(pose_x_reg) + SUM_W'(rx_reg));
    assign pose_y_next = sat_pose(SUM_W'(pose_y_reg) + SUM_W'(ry_reg));
    assign pose_h_next = pose_h_reg + dh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pose_x_reg <= '0;
            pose_y_reg <= '0;
            pose_h_reg <= '0;
        end else if (cmd.update) begin
            pose_x_reg <= pose_x_next;
            pose_y_reg <= pose_y_next;
            pose_h_reg <= pose_h_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dh_reg <= s_tdata[S_TDATA_W-1:2*FIELD_W];
        end
        if (cmd.load || cmd.rotate) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
        if (cmd.scale) begin
            acc_reg <= acc_next;
            if (cmd.phase == MUL_XH) begin
                rx_reg <= acc_next[ACC_W-1:ROUND_SHIFT];
            end
            if (cmd.phase == MUL_YH) begin
                ry_reg <= acc_next[ACC_W-1:ROUND_SHIFT];
            end
        end
        if (cmd.update) begin
            m_data_reg <= {pose_h_next, WORLD_W'(pose_y_next), WORLD_W'(pose_x_next)};
        end
    end

    assign m_tdata = m_data_reg;

endmodule

// ===== design/podo_ctrl.sv =====
// ---------------------------------------------------------------------------
// podo_ctrl
// Sequencer: accept, CORDIC iterations, gain multiply phases, pose update and
// result register valid.
// ---------------------------------------------------------------------------
module podo_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output podo_pkg::podo_cmd_t cmd
);
    import podo_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_SCALE,
        ST_UPDATE
    } state_t;

    state_t            state_reg;
    logic [ITER_W-1:0] iter_reg;
    mul_phase_t        phase_reg;
    logic              m_tvalid_reg;
    logic              out_free;

    // result register can take a new pose this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd.load   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.rotate = (state_reg == ST_ROTATE);
        cmd.iter   = iter_reg;
        cmd.scale  = (state_reg == ST_SCALE);
        cmd.phase  = phase_reg;
        cmd.update = (state_reg == ST_UPDATE) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            iter_reg     <= '0;
            phase_reg    <= MUL_XL;
            m_tvalid_reg <= 1'b0;
        end else begin
            // a new pose keeps valid high even when the old one leaves
            if (cmd.update) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_ROTATE;
                        iter_reg  <= '0;
                    end
                end
                ST_ROTATE: begin
                    if (iter_reg == ITER_W'(ROT_STEPS - 1)) begin
                        state_reg <= ST_SCALE;
                        phase_reg <= MUL_XL;
                    end else begin
                        iter_reg <= iter_reg + ITER_W'(1);
                    end
                end
                ST_SCALE: begin
                    unique case (phase_reg)
                        MUL_XL: phase_reg <= MUL_XH;
                        MUL_XH: phase_reg <= MUL_YL;
                        MUL_YL: phase_reg <= MUL_YH;
                        MUL_YH: begin
                            phase_reg <= MUL_XL;
                            state_reg <= ST_UPDATE;
                        end
                    endcase
                end
                ST_UPDATE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== design/planar_odometry_pose_integrator_top.sv =====
// ---------------------------------------------------------------------------
// Planar odometry pose integrator
// Integrates robot-frame displacements into a world pose with saturating position.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream carries one displacement per request: delta_x, delta_y and
//   delta_heading. The block rotates (delta_x, delta_y) by the stored heading
//   with a shared CORDIC stage, one micro-rotation per cycle, scales out the
//   CORDIC gain with one 19x31 multiplier in four partial products, adds
//   to the stored position with saturation and advances the heading.
//   After accept, the rotation iterations, the four multiply phases and the
//   update step run in turn before m_tvalid rises. A request is processed
//   through these steps before the next one is accepted.
//   s_tready is high only while the sequencer is idle. A finished pose sits in
//   the output register, and the next request may be accepted and processed
//   meanwhile; if the receiver still stalls when that one finishes, the
//   sequencer holds in its update step until the register frees.
//   Reset clears the pose and heading to zero and empties the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module planar_odometry_pose_integrator_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] delta_x, [31:16] delta_y, [47:32] delta_heading
    input  logic [podo_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] world_x, [63:32] world_y, [79:64] world_heading
    output logic [podo_pkg::M_TDATA_W-1:0] m_tdata
);
    import podo_pkg::*;

    podo_cmd_t cmd;

    podo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    podo_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

    `ASSERT_IMP(a_cmd_exclusive, 1'b1, $onehot0({cmd.load, cmd.rotate, cmd.scale, cmd.update}))
    `ASSERT_IMP(a_no_overwrite, cmd.update, !m_tvalid || m_tready)
    `ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `ASSERT_NXT(a_update_gives_valid, cmd.update, m_tvalid)

endmodule
